### design/gbm_pkg.sv
// Shared types, constants and elaboration-time helpers for the Box-Muller
// Gaussian generator. No dependencies.
`timescale 1ns / 1ps

package gbm_pkg;

  localparam int UNIFORM_BITS_DEF = 16;
  localparam int FUNC_ITER_DEF    = 16;

  localparam int CODE_W      = 16;
  localparam int SAMPLE_W    = 18;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MEAN  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE = CFG_INDEX_W'(1);

  localparam logic signed [CFG_W-1:0] MEAN_RESET  = CFG_W'(0);
  localparam logic [CFG_W-1:0]        SCALE_RESET = CFG_W'(4096);

  // datapath widths
  localparam int DQ_W     = 29;  // -log2(u) in Q24
  localparam int W_W      = 30;  // -2 ln u in Q24
  localparam int RT_W     = 56;  // square root remainder / root working width
  localparam int R_W      = 27;  // final root, Q24
  localparam int SQ_STEPS = 27;  // root digits
  localparam int CV_W     = 33;  // cordic x, y, z
  localparam int PH_W     = 28;  // phase remainder within a quadrant

  localparam logic [14:0] LN4_HI    = 15'h58B9;  // 2 ln 2, Q30, split
  localparam logic [15:0] LN4_LO    = 16'h0BFC;
  localparam logic [15:0] HALFPI_HI = 16'h6487;  // pi/2, Q30, split
  localparam logic [15:0] HALFPI_LO = 16'hED51;

  localparam logic signed [CV_W-1:0] CORDIC_GAIN = CV_W'(652032875);

  localparam logic signed [SAMPLE_W-1:0] OUT_MAX = SAMPLE_W'(131071);
  localparam logic signed [SAMPLE_W-1:0] OUT_MIN = SAMPLE_W'(-131072);

  typedef struct packed {
    logic [CODE_W-1:0] u_code;
    logic [CODE_W-1:0] v_code;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] normal_sample;
    logic                       saturated;
  } rsp_t;

  function automatic logic signed [CV_W-1:0] atan_entry(input int i);
    logic signed [CV_W-1:0] a;
    case (i)
      0: a = CV_W'(843314857);
      1: a = CV_W'(497837830);
      2: a = CV_W'(263043837);
      3: a = CV_W'(133525159);
      4: a = CV_W'(67021687);
      5: a = CV_W'(33543515);
      6: a = CV_W'(16775851);
      7: a = CV_W'(8388437);
      8: a = CV_W'(4194283);
      9: a = CV_W'(2097149);
      default: a = (i <= 30) ? (CV_W'(1) <<< (30 - i)) : '0;
    endcase
    return a;
  endfunction

  // log2 with iters fraction bits; used on constants only
  function automatic logic [63:0] log2_fixed(input logic [31:0] c, input int iters);
    int e;
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] frac;
    e = 0;
    for (int k = 0; k < 32; k++) begin
      if (c[k]) e = k;
    end
    m = 64'(c) << (31 - e);
    frac = '0;
    for (int i = 0; i < iters; i++) begin
      sq = m * m;
      m = sq >> 31;
      frac = frac << 1;
      if (m[32]) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(e[4:0]) << iters) | frac;
  endfunction

endpackage

### design/gbm_log_cell.sv
// One squaring step of the log2 mantissa chain.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module gbm_log_cell #(
  parameter int FRAC_W = 16,
  parameter int TAG_W  = 6
) (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       m_in,
  input  logic [FRAC_W-1:0] frac_in,
  input  logic [TAG_W-1:0]  tag_in,
  output logic [31:0]       m_out,
  output logic [FRAC_W-1:0] frac_out,
  output logic [TAG_W-1:0]  tag_out
);

  logic [63:0] sq;
  logic [32:0] t;
  logic [31:0] m_next;

  always_comb begin
    sq = 64'(m_in) * 64'(m_in);
    t = sq[63:31];
    m_next = t[32] ? t[32:1] : t[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_out    <= m_next;
      frac_out <= {frac_in[FRAC_W-2:0], t[32]};
      tag_out  <= tag_in;
    end
  end

endmodule

### design/gbm_cordic_cell.sv
// One CORDIC rotation step in rotation mode.
// Depends on gbm_pkg for widths and the arctangent table.
`timescale 1ns / 1ps

module gbm_cordic_cell #(
  parameter int STEP  = 0,
  parameter int TAG_W = 2
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [gbm_pkg::CV_W-1:0] x_in,
  input  logic signed [gbm_pkg::CV_W-1:0] y_in,
  input  logic signed [gbm_pkg::CV_W-1:0] z_in,
  input  logic [TAG_W-1:0]                tag_in,
  output logic signed [gbm_pkg::CV_W-1:0] x_out,
  output logic signed [gbm_pkg::CV_W-1:0] y_out,
  output logic signed [gbm_pkg::CV_W-1:0] z_out,
  output logic [TAG_W-1:0]                tag_out
);

  localparam logic signed [gbm_pkg::CV_W-1:0] ATAN = gbm_pkg::atan_entry(STEP);

  logic signed [gbm_pkg::CV_W-1:0] xs;
  logic signed [gbm_pkg::CV_W-1:0] ys;

  assign xs = x_in >>> STEP;
  assign ys = y_in >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (z_in >= 0) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end
      tag_out <= tag_in;
    end
  end

endmodule

### design/gbm_sqrt_cell.sv
// One digit of the restoring integer square root.
// Depends on gbm_pkg for the working width.
`timescale 1ns / 1ps

module gbm_sqrt_cell #(
  parameter int K     = 0,
  parameter int TAG_W = 34
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [gbm_pkg::RT_W-1:0]        rem_in,
  input  logic [gbm_pkg::RT_W-1:0]        root_in,
  input  logic [TAG_W-1:0]                tag_in,
  output logic [gbm_pkg::RT_W-1:0]        rem_out,
  output logic [gbm_pkg::RT_W-1:0]        root_out,
  output logic [TAG_W-1:0]                tag_out
);

  localparam logic [gbm_pkg::RT_W-1:0] BITV = gbm_pkg::RT_W'(1) << (2 * K);

  logic [gbm_pkg::RT_W-1:0] trial;

  assign trial = root_in + BITV;

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_in >= trial) begin
        rem_out  <= rem_in - trial;
        root_out <= (root_in >> 1) + BITV;
      end else begin
        rem_out  <= rem_in;
        root_out <= root_in >> 1;
      end
      tag_out <= tag_in;
    end
  end

endmodule

### design/gaussian_box_muller_core.sv
// Box-Muller Gaussian generator top level: front end, log2, CORDIC and root
// cell chains, scaling and saturation. Depends on gbm_pkg and the three cells.
//
// One item enters per cycle while the result side does not stall. Its result
// passes in order through the input and normalize registers, the log2 squaring
// chain (FUNC_ITERATIONS cells), three scaling stages, the 27-cell square root
// chain and three output stages; the CORDIC chain runs beside the log2 chain.
// A stall on the result side holds the whole pipeline. mean_offset and
// std_scale are sampled at the output stages, so write them while idle.
`timescale 1ns / 1ps

module gaussian_box_muller_core #(
  parameter int UNIFORM_BITS    = gbm_pkg::UNIFORM_BITS_DEF,
  parameter int FUNC_ITERATIONS = gbm_pkg::FUNC_ITER_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  gbm_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output gbm_pkg::rsp_t                     rsp,
  input  logic                              cfg_we,
  input  logic [gbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gbm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int UB    = UNIFORM_BITS;
  localparam int FI    = FUNC_ITERATIONS;
  localparam int LC_W  = 5 + FI;
  localparam int VL    = FI + 34;
  localparam int LTAG  = 6;
  localparam int STAG  = gbm_pkg::CV_W + 1;
  localparam logic [31:0] CODE_MAX = 32'((64'd1 << UB) - 64'd1);
  localparam logic [63:0] LM_FULL  = gbm_pkg::log2_fixed(CODE_MAX, FI);
  localparam logic [LC_W-1:0] LM   = LC_W'(LM_FULL);

  logic adv;
  logic [VL-1:0] vld;

  logic signed [gbm_pkg::CFG_W-1:0] mean_offset;
  logic [gbm_pkg::CFG_W-1:0]        std_scale;

  assign adv = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset <= gbm_pkg::MEAN_RESET;
      std_scale   <= gbm_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        gbm_pkg::REG_MEAN:  mean_offset <= $signed(cfg_data);
        gbm_pkg::REG_SCALE: std_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[VL-2:0], req_valid};
    end
  end

  // input register
  logic [UB-1:0] a_u;
  logic [UB-1:0] a_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_u <= UB'(req.u_code);
      a_v <= UB'(req.v_code);
    end
  end

  // normalize u; phase of v is the repeating binary expansion of v/M
  logic [4:0]  b_e_next;
  logic [29:0] p_raw;
  logic [29:0] p_next;

  always_comb begin
    b_e_next = '0;
    for (int k = 0; k < UB; k++) begin
      if (a_u[k]) b_e_next = 5'(k);
    end
  end

  for (genvar k = 0; k < 30; k++) begin : g_phase
    localparam int SRC = UB - 1 - (k % UB);
    assign p_raw[29-k] = a_v[SRC];
  end

  assign p_next = (a_v == CODE_MAX[UB-1:0]) ? '0 : p_raw;

  logic [31:0]                 b_m;
  logic [LTAG-1:0]             b_tag;
  logic [gbm_pkg::PH_W-1:0]    b_r;
  logic [1:0]                  b_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      b_m   <= 32'(a_u) << (5'd31 - b_e_next);
      b_tag <= {b_e_next, (a_u == '0)};
      b_r   <= p_next[27:0];
      b_q   <= p_next[29:28];
    end
  end

  // log2 chain
  logic [31:0]     lg_m   [0:FI];
  logic [FI-1:0]   lg_f   [0:FI];
  logic [LTAG-1:0] lg_tag [0:FI];

  assign lg_m[0]   = b_m;
  assign lg_f[0]   = '0;
  assign lg_tag[0] = b_tag;

  for (genvar i = 0; i < FI; i++) begin : g_log
    gbm_log_cell #(.FRAC_W(FI), .TAG_W(LTAG)) u_cell (
      .clk      (clk),
      .en       (adv),
      .m_in     (lg_m[i]),
      .frac_in  (lg_f[i]),
      .tag_in   (lg_tag[i]),
      .m_out    (lg_m[i+1]),
      .frac_out (lg_f[i+1]),
      .tag_out  (lg_tag[i+1])
    );
  end

  logic [LC_W-1:0]         lc;
  logic [LC_W-1:0]         d_raw;
  logic [gbm_pkg::DQ_W-1:0] dq_next;

  assign lc    = {lg_tag[FI][5:1], lg_f[FI]};
  assign d_raw = (LM > lc) ? LM - lc : '0;

  if (FI >= 24) begin : g_dq_down
    assign dq_next = gbm_pkg::DQ_W'(d_raw >> (FI - 24));
  end else begin : g_dq_up
    assign dq_next = gbm_pkg::DQ_W'(d_raw) << (24 - FI);
  end

  logic [gbm_pkg::DQ_W-1:0] d_q;
  logic                     d_uz;
  logic [43:0]              m_hi;
  logic [44:0]              m_lo;
  logic                     m_uz;
  logic [gbm_pkg::W_W-1:0]  w_val;
  logic                     w_uz;
  logic [59:0]              w_sum;

  assign w_sum = (60'(m_hi) << 16) + 60'(m_lo);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_q   <= dq_next;
      d_uz  <= lg_tag[FI][0];
      m_hi  <= 44'(d_q) * 44'(gbm_pkg::LN4_HI);
      m_lo  <= 45'(d_q) * 45'(gbm_pkg::LN4_LO);
      m_uz  <= d_uz;
      w_val <= w_sum[59:30];
      w_uz  <= m_uz;
    end
  end

  // angle and CORDIC chain
  logic [43:0] c_ph;
  logic [43:0] c_pl;
  logic [1:0]  c_q;
  logic [59:0] z_sum;

  assign z_sum = (60'(c_ph) << 16) + 60'(c_pl);

  logic signed [gbm_pkg::CV_W-1:0] cx [0:FI];
  logic signed [gbm_pkg::CV_W-1:0] cy [0:FI];
  logic signed [gbm_pkg::CV_W-1:0] cz [0:FI];
  logic [1:0]                      cq [0:FI];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ph  <= 44'(b_r) * 44'(gbm_pkg::HALFPI_HI);
      c_pl  <= 44'(b_r) * 44'(gbm_pkg::HALFPI_LO);
      c_q   <= b_q;
      cz[0] <= $signed(gbm_pkg::CV_W'(z_sum[59:28]));
      cq[0] <= c_q;
    end
  end

  assign cx[0] = gbm_pkg::CORDIC_GAIN;
  assign cy[0] = '0;

  for (genvar i = 0; i < FI; i++) begin : g_cordic
    gbm_cordic_cell #(.STEP(i), .TAG_W(2)) u_cell (
      .clk     (clk),
      .en      (adv),
      .x_in    (cx[i]),
      .y_in    (cy[i]),
      .z_in    (cz[i]),
      .tag_in  (cq[i]),
      .x_out   (cx[i+1]),
      .y_out   (cy[i+1]),
      .z_out   (cz[i+1]),
      .tag_out (cq[i+1])
    );
  end

  logic signed [gbm_pkg::CV_W-1:0] cos_next;
  logic signed [gbm_pkg::CV_W-1:0] cos_q;

  always_comb begin
    case (cq[FI])
      2'd0:    cos_next = cx[FI];
      2'd1:    cos_next = -cy[FI];
      2'd2:    cos_next = -cx[FI];
      default: cos_next = cy[FI];
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) cos_q <= cos_next;
  end

  // square root chain, cosine rides along
  logic [gbm_pkg::RT_W-1:0] sr_rem  [0:gbm_pkg::SQ_STEPS];
  logic [gbm_pkg::RT_W-1:0] sr_root [0:gbm_pkg::SQ_STEPS];
  logic [STAG-1:0]          sr_tag  [0:gbm_pkg::SQ_STEPS];

  assign sr_rem[0]  = gbm_pkg::RT_W'({w_val, 24'b0});
  assign sr_root[0] = '0;
  assign sr_tag[0]  = {cos_q, w_uz};

  for (genvar i = 0; i < gbm_pkg::SQ_STEPS; i++) begin : g_sqrt
    gbm_sqrt_cell #(.K(gbm_pkg::SQ_STEPS - 1 - i), .TAG_W(STAG)) u_cell (
      .clk      (clk),
      .en       (adv),
      .rem_in   (sr_rem[i]),
      .root_in  (sr_root[i]),
      .tag_in   (sr_tag[i]),
      .rem_out  (sr_rem[i+1]),
      .root_out (sr_root[i+1]),
      .tag_out  (sr_tag[i+1])
    );
  end

  // scaling
  logic signed [gbm_pkg::CV_W-1:0] sq_cos;
  logic signed [60:0]              x_prod;

  assign sq_cos = $signed(sr_tag[gbm_pkg::SQ_STEPS][STAG-1:1]);
  assign x_prod = $signed({1'b0, sr_root[gbm_pkg::SQ_STEPS][gbm_pkg::R_W-1:0]}) * sq_cos;

  logic signed [28:0]              x_val;
  logic signed [gbm_pkg::CV_W-1:0] x_cos;
  logic                            x_uz;

  logic signed [45:0] t_prod;
  logic signed [19:0] t_term;
  logic signed [gbm_pkg::CV_W-1:0] t_cos;
  logic                            t_uz;

  assign t_prod = x_val * $signed({1'b0, std_scale}) + 46'sd33554432;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_val  <= 29'(x_prod >>> 30);
      x_cos  <= sq_cos;
      x_uz   <= sr_tag[gbm_pkg::SQ_STEPS][0];
      t_term <= 20'(t_prod >>> 26);
      t_cos  <= x_cos;
      t_uz   <= x_uz;
    end
  end

  // offset and saturation
  logic signed [20:0]                   o_sum;
  logic signed [gbm_pkg::SAMPLE_W-1:0]  o_smp;
  logic                                 o_sat;

  always_comb begin
    o_sum = 21'(mean_offset) + 21'(t_term);
    o_sat = 1'b0;
    o_smp = gbm_pkg::SAMPLE_W'(o_sum);
    if (t_uz) begin
      o_sat = 1'b1;
      if (std_scale == '0 || t_cos == '0) begin
        o_smp = gbm_pkg::SAMPLE_W'(mean_offset);
      end else if (t_cos > 0) begin
        o_smp = gbm_pkg::OUT_MAX;
      end else begin
        o_smp = gbm_pkg::OUT_MIN;
      end
    end else if (o_sum > 21'(gbm_pkg::OUT_MAX)) begin
      o_sat = 1'b1;
      o_smp = gbm_pkg::OUT_MAX;
    end else if (o_sum < 21'(gbm_pkg::OUT_MIN)) begin
      o_sat = 1'b1;
      o_smp = gbm_pkg::OUT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= vld[VL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.normal_sample <= o_smp;
      rsp.saturated     <= o_sat;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while held");

  a_deliver: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[VL-1]) |=> rsp_valid)
    else $error("finished item not presented");

  a_zero_u: assert property (@(posedge clk) disable iff (rst)
    (adv && vld[VL-1] && t_uz) |=> rsp.saturated)
    else $error("zero u item not flagged");

endmodule

### tb/testbench.sv
// Testbench for gaussian_box_muller_core: directed table then random items, each
// checked against the table or fixed-point Box-Muller predictor. Depends on gbm_pkg.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = gbm_pkg::FUNC_ITER_DEF + 35;
  localparam int LIMIT   = 600000;
  localparam longint unsigned CODE_MAX = 65535;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  gbm_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  gbm_pkg::rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [gbm_pkg::CFG_INDEX_W-1:0] cfg_index = gbm_pkg::REG_MEAN;
  logic [gbm_pkg::CFG_W-1:0] cfg_data = '0;

  gaussian_box_muller_core i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [15:0] mu_reg;
  logic [15:0] sigma_reg;
  gbm_pkg::rsp_t sample_q[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_sat = 0;
  int stall_cnt = 0;
  bit quiet = 1'b0;

  typedef struct {
    logic [15:0] u;
    logic [15:0] v;
    bit typed;
    logic signed [17:0] smp;
    logic sat;
  } row_t;

  function automatic longint unsigned log2_q16(longint unsigned c);
    int e;
    longint unsigned m, f;
    e = 0;
    while (e < 31 && (c >> (e + 1)) != 0) e++;
    m = c << (31 - e);
    f = 0;
    for (int i = 0; i < gbm_pkg::FUNC_ITER_DEF; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return (longint'(e) << gbm_pkg::FUNC_ITER_DEF) | f;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint arctan_q30(int i);
    longint tbl[10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                        33543515, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return tbl[i];
    if (i <= 30) return longint'(1) << (30 - i);
    return 0;
  endfunction

  function automatic longint cos_turns(longint unsigned p);
    longint unsigned r;
    int q;
    longint x, y, z, nx;
    p = p & ((64'd1 << 30) - 1);
    q = int'((p >> 28) & 3);
    r = p & ((64'd1 << 28) - 1);
    z = longint'((r * 64'd1686629713) >> 28);
    x = 652032875;
    y = 0;
    for (int i = 0; i < gbm_pkg::FUNC_ITER_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - arctan_q30(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + arctan_q30(i);
      end
      x = nx;
    end
    case (q)
      0: return x;
      1: return -y;
      2: return -x;
      default: return y;
    endcase
  endfunction

  function automatic gbm_pkg::rsp_t gaussian_of(logic [15:0] uc, logic [15:0] vc);
    gbm_pkg::rsp_t o;
    longint c, s, xs, term, mu, sg;
    longint unsigned lm, lc, d, w, r;
    mu = longint'(mu_reg);
    sg = longint'(sigma_reg);
    c = cos_turns((longint'(vc) << 30) / CODE_MAX);
    o.saturated = 1'b0;
    if (uc == 0) begin
      o.saturated = 1'b1;
      if (sg == 0 || c == 0) s = mu;
      else s = (c > 0) ? 131071 : -131072;
    end else begin
      lm = log2_q16(CODE_MAX);
      lc = log2_q16(longint'(uc));
      d = (lm > lc) ? lm - lc : 0;
      d = d << (24 - gbm_pkg::FUNC_ITER_DEF);
      w = (d * 64'd1488522236) >> 30;
      r = int_sqrt(w << 24);
      xs = (longint'(r) * c) >>> 30;
      term = (xs * sg + (longint'(1) << 25)) >>> 26;
      s = mu + term;
      if (s > 131071) begin s = 131071; o.saturated = 1'b1; end
      if (s < -131072) begin s = -131072; o.saturated = 1'b1; end
    end
    o.normal_sample = s[17:0];
    return o;
  endfunction

  task automatic report_mismatch(string what, gbm_pkg::rsp_t got, gbm_pkg::rsp_t want);
    errors++;
    if (errors <= 20)
      $display("mismatch %s: got %0d/%0b want %0d/%0b at cycle %0d", what,
               got.normal_sample, got.saturated, want.normal_sample, want.saturated,
               cycles);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (sample_q.size() == 0) begin
        report_mismatch("unexpected item", rsp, '0);
      end else begin
        if (rsp.normal_sample !== sample_q[0].normal_sample)
          report_mismatch("normal_sample", rsp, sample_q[0]);
        else if (rsp.saturated !== sample_q[0].saturated)
          report_mismatch("saturated", rsp, sample_q[0]);
        if (sample_q[0].saturated) n_sat++;
        void'(sample_q.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (stall_cnt > 0) stall_cnt--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 18);
      if (quiet) stall_cnt = 0;
      rsp_stall <= (stall_cnt != 0);
    end
  end

  task automatic send_item(logic [15:0] u, logic [15:0] v, bit typed, gbm_pkg::rsp_t want);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    req_valid <= 1'b1;
    req.u_code <= u;
    req.v_code <= v;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    sample_q = {sample_q, (typed ? want : gaussian_of(u, v))};
    n_items++;
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [gbm_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == gbm_pkg::REG_MEAN) mu_reg = val;
    else sigma_reg = val;
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 16));
      3: return 16'($urandom_range(65500, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  row_t dir_rows[16] = '{
    '{16'd0, 16'd0, 1, 18'sd131071, 1'b1},
    '{16'd0, 16'd32768, 1, -18'sd131072, 1'b1},
    '{16'hFFFF, 16'd0, 1, 18'sd0, 1'b0},
    '{16'hFFFF, 16'hFFFF, 1, 18'sd0, 1'b0},
    '{16'hFFFF, 16'd12345, 1, 18'sd0, 1'b0},
    '{16'd0, 16'hFFFF, 1, 18'sd131071, 1'b1},
    '{16'd1, 16'd0, 0, 0, 0},
    '{16'd1, 16'd32768, 0, 0, 0},
    '{16'd1, 16'd16384, 0, 0, 0},
    '{16'd1, 16'd49152, 0, 0, 0},
    '{16'd0, 16'd16384, 0, 0, 0},
    '{16'd0, 16'd49151, 0, 0, 0},
    '{16'd32768, 16'd8192, 0, 0, 0},
    '{16'd2, 16'hFFFE, 0, 0, 0},
    '{16'h5555, 16'hAAAA, 0, 0, 0},
    '{16'hAAAA, 16'h5555, 0, 0, 0}
  };

  logic signed [15:0] mu_set[5] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd1024};
  logic [15:0] sg_set[5] = '{16'd4096, 16'd65535, 16'd65535, 16'd0, 16'd1};

  initial begin
    gbm_pkg::rsp_t want;
    mu_reg = gbm_pkg::MEAN_RESET;
    sigma_reg = gbm_pkg::SCALE_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[k]) begin
      want.normal_sample = dir_rows[k].smp;
      want.saturated = dir_rows[k].sat;
      send_item(dir_rows[k].u, dir_rows[k].v, dir_rows[k].typed, want);
    end
    drain;

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        write_reg(gbm_pkg::REG_MEAN, mu_set[ph]);
        write_reg(gbm_pkg::REG_SCALE, sg_set[ph]);
      end else begin
        write_reg(gbm_pkg::REG_MEAN, 16'($urandom));
        write_reg(gbm_pkg::REG_SCALE, 16'($urandom));
        quiet = 1'b1;
      end
      for (int k = 0; k < 215; k++) send_item(pick_code(), pick_code(), 0, want);
      drain;
    end

    $display("%0d items over six register settings incl. extremes, %0d saturated results",
             n_items, n_sat);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
design/gbm_pkg.sv
design/gbm_log_cell.sv
design/gbm_cordic_cell.sv
design/gbm_sqrt_cell.sv
design/gaussian_box_muller_core.sv
tb/testbench.sv
